// File: hdl/pdb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the periodic 3D density binner.
// No dependencies; imported by every other file of the block but pdb_fifo.
package pdb_pkg;

    // Fixed field widths of the result and configuration words.
    localparam int IDX_W      = 15;
    localparam int OUT_CNT_W  = 32;
    localparam int FRAME_W    = 32;
    localparam int POS_W      = 32;
    localparam int BOX_W      = 31;
    localparam int BPU_W      = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    // Widest linear bin address over the whole parameter range.
    localparam int ADDR_W_MAX = 24;

    typedef enum logic [1:0] {
        ACT_DEPOSIT = 2'd0,
        ACT_FRAME   = 2'd1,
        ACT_READ    = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_X      = 3'd0,
        REG_BOX_Y      = 3'd1,
        REG_BOX_Z      = 3'd2,
        REG_BPU_X      = 3'd3,
        REG_BPU_Y      = 3'd4,
        REG_BPU_Z      = 3'd5,
        REG_GRID_SHAPE = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [BOX_W-1:0] box_x;
        logic [BOX_W-1:0] box_y;
        logic [BOX_W-1:0] box_z;
        logic [BPU_W-1:0] bpu_x;
        logic [BPU_W-1:0] bpu_y;
        logic [BPU_W-1:0] bpu_z;
    } cfg_t;

    typedef struct packed {
        action_t               action;
        logic [ADDR_W_MAX-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]     bin_index;
        logic [OUT_CNT_W-1:0] bin_count;
        logic [FRAME_W-1:0]   frame_count;
        logic                 saturated;
    } result_t;

endpackage

// File: hdl/pdb_fifo.sv
`timescale 1ns / 1ps
// Small synchronous queue used between the binner stages and at the output.
// Standalone; carries packed words of WIDTH bits.
module pdb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (PTR_W+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hdl/pdb_front.sv
`timescale 1ns / 1ps
// Front end of the binner: takes one word, wraps and scales the coordinates,
// builds the bin address, reduces it if needed, queues a command. Uses pdb_pkg.
module pdb_front #(
    parameter int AXIS_BITS = 5,
    parameter int BIN_DEPTH = 32768
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_take,
    input  logic [1:0]                   action,
    input  logic signed [31:0]           pos_x,
    input  logic signed [31:0]           pos_y,
    input  logic signed [31:0]           pos_z,
    input  logic [14:0]                  read_index,
    input  pdb_pkg::cfg_t                cfg,
    input  logic [3*AXIS_BITS-1:0]       grid_shape,
    output logic                         busy,
    output logic                         cmd_push,
    output pdb_pkg::cmd_t                cmd,
    input  logic                         cmd_full
);

    import pdb_pkg::*;

    localparam int LIN_BITS  = (3 * AXIS_BITS > IDX_W) ? 3 * AXIS_BITS : IDX_W;
    localparam bit NEED_MOD  = (BIN_DEPTH < (1 << LIN_BITS));
    // Reciprocal of the store depth; the quotient estimate is exact or one low.
    localparam longint RECIP = (longint'(1) << LIN_BITS) / longint'(BIN_DEPTH);
    localparam int L1_BITS   = 2 * AXIS_BITS;
    localparam int L2_BITS   = 3 * AXIS_BITS;

    typedef enum logic [3:0] {
        F_IDLE,
        F_WRAP,
        F_MUL,
        F_CLAMP,
        F_LIN,
        F_MOD,
        F_REM,
        F_FIX,
        F_PUSH
    } fstate_t;

    fstate_t                 state_reg;
    action_t                 act_reg;
    logic signed [POS_W-1:0] pos_reg   [3];
    logic [BOX_W-1:0]        pw_reg    [3];
    logic                    neg_reg   [3];
    logic [BOX_W-1:0]        prod_reg  [3];
    logic [L1_BITS-1:0]      lin1_reg;
    logic [AXIS_BITS-1:0]    iz_reg;
    logic [LIN_BITS-1:0]     lin_reg;
    logic [LIN_BITS-1:0]     q_reg;

    logic [BOX_W-1:0]        box       [3];
    logic [BPU_W-1:0]        bpu       [3];
    logic [AXIS_BITS-1:0]    nmax      [3];
    logic signed [POS_W:0]   p_s       [3];
    logic signed [POS_W:0]   b_s       [3];
    logic signed [POS_W:0]   w_s       [3];
    logic [62:0]             mul       [3];
    logic [AXIS_BITS-1:0]    idx       [3];
    logic [L1_BITS:0]        lin1_full;
    logic [L2_BITS:0]        lin_full;
    logic [2*LIN_BITS-1:0]   quot_full;
    logic [2*LIN_BITS-1:0]   back_mul;
    logic [LIN_BITS:0]       depth_w;

    assign box[0]  = cfg.box_x;
    assign box[1]  = cfg.box_y;
    assign box[2]  = cfg.box_z;
    assign bpu[0]  = cfg.bpu_x;
    assign bpu[1]  = cfg.bpu_y;
    assign bpu[2]  = cfg.bpu_z;
    assign nmax[0] = grid_shape[AXIS_BITS-1:0];
    assign nmax[1] = grid_shape[2*AXIS_BITS-1:AXIS_BITS];
    assign nmax[2] = grid_shape[3*AXIS_BITS-1:2*AXIS_BITS];

    // Per-axis wrap, scale and clamp; the three axes are independent.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            p_s[a] = $signed({pos_reg[a][POS_W-1], pos_reg[a]});
            b_s[a] = $signed({2'b00, box[a]});
            if (p_s[a] >= b_s[a])
            begin
                w_s[a] = p_s[a] - b_s[a];
            end
            else if (p_s[a] < 0)
            begin
                w_s[a] = p_s[a] + b_s[a];
            end
            else
            begin
                w_s[a] = p_s[a];
            end
            mul[a] = 63'(pw_reg[a]) * 63'(bpu[a]);
            idx[a] = (prod_reg[a] > BOX_W'(nmax[a])) ? nmax[a]
                                                       : prod_reg[a][AXIS_BITS-1:0];
        end
    end

    assign lin1_full = (L1_BITS+1)'(idx[0]) * (L1_BITS+1)'({1'b0, nmax[1]} + 1'b1)
                     + (L1_BITS+1)'(idx[1]);
    assign lin_full  = (L2_BITS+1)'(lin1_reg) * (L2_BITS+1)'({1'b0, nmax[2]} + 1'b1)
                     + (L2_BITS+1)'(iz_reg);
    // Reduction modulo the store depth: estimate the quotient by reciprocal,
    // subtract quotient times depth, then one final compare and subtract.
    assign quot_full = (2*LIN_BITS)'(lin_reg) * (2*LIN_BITS)'(RECIP);
    assign back_mul  = (2*LIN_BITS)'(q_reg) * (2*LIN_BITS)'(BIN_DEPTH);
    assign depth_w   = (LIN_BITS+1)'(BIN_DEPTH);

    assign busy       = (state_reg != F_IDLE);
    assign cmd_push   = (state_reg == F_PUSH) && !cmd_full;
    assign cmd.action = act_reg;
    assign cmd.addr   = ADDR_W_MAX'(lin_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            act_reg   <= ACT_DEPOSIT;
            for (int a = 0; a < 3; a++)
            begin
                pos_reg[a]  <= '0;
                pw_reg[a]   <= '0;
                neg_reg[a]  <= 1'b0;
                prod_reg[a] <= '0;
            end
            lin1_reg  <= '0;
            iz_reg    <= '0;
            lin_reg   <= '0;
            q_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_take)
                    begin
                        act_reg    <= action_t'(action);
                        pos_reg[0] <= pos_x;
                        pos_reg[1] <= pos_y;
                        pos_reg[2] <= pos_z;
                        lin_reg    <= LIN_BITS'(read_index);
                        case (action_t'(action))
                            ACT_DEPOSIT: state_reg <= F_WRAP;
                            ACT_READ:    state_reg <= NEED_MOD ? F_MOD : F_PUSH;
                            default:     state_reg <= F_PUSH;
                        endcase
                    end
                end
                F_WRAP:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        pw_reg[a]  <= w_s[a][BOX_W-1:0];
                        neg_reg[a] <= w_s[a][POS_W];
                    end
                    state_reg <= F_MUL;
                end
                F_MUL:
                begin
                    // Still negative after one wrap: bin zero.
                    for (int a = 0; a < 3; a++)
                    begin
                        prod_reg[a] <= neg_reg[a] ? '0 : mul[a][62:32];
                    end
                    state_reg <= F_CLAMP;
                end
                F_CLAMP:
                begin
                    lin1_reg  <= L1_BITS'(lin1_full);
                    iz_reg    <= idx[2];
                    state_reg <= F_LIN;
                end
                F_LIN:
                begin
                    lin_reg   <= LIN_BITS'(lin_full);
                    state_reg <= NEED_MOD ? F_MOD : F_PUSH;
                end
                F_MOD:
                begin
                    q_reg     <= quot_full[2*LIN_BITS-1:LIN_BITS];
                    state_reg <= F_REM;
                end
                F_REM:
                begin
                    lin_reg   <= lin_reg - back_mul[LIN_BITS-1:0];
                    state_reg <= F_FIX;
                end
                F_FIX:
                begin
                    if ({1'b0, lin_reg} >= depth_w)
                    begin
                        lin_reg <= lin_reg - depth_w[LIN_BITS-1:0];
                    end
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!cmd_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/pdb_back.sv
`timescale 1ns / 1ps
// Back end of the binner: owns the count store and the frame counter, runs
// read-modify-write, reads, frame ends and the clearing sweep. Uses pdb_pkg.
module pdb_back #(
    parameter int BIN_DEPTH  = 32768,
    parameter int COUNT_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_empty,
    input  pdb_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    input  logic               res_full,
    output logic               res_push,
    output pdb_pkg::result_t   res,
    output logic               init_busy
);

    import pdb_pkg::*;

    localparam int ADDR_BITS = $clog2(BIN_DEPTH);

    typedef enum logic [1:0] {
        B_INIT,
        B_IDLE,
        B_UPDATE,
        B_CLEAR
    } bstate_t;

    bstate_t                state_reg;
    logic [ADDR_BITS-1:0]   ptr_reg;
    action_t                act_reg;
    logic [ADDR_BITS-1:0]   addr_reg;
    logic [FRAME_W-1:0]     frames_reg;

    logic [COUNT_BITS-1:0]  mem [BIN_DEPTH];
    logic [COUNT_BITS-1:0]  rd_data_reg;

    logic [FRAME_W-1:0]     frames_next;
    logic [COUNT_BITS-1:0]  inc;
    logic [COUNT_BITS-1:0]  cnt;
    logic [63:0]            cnt_w;
    logic [ADDR_W_MAX-1:0]  addr_w;
    logic                   sweep;
    logic                   ptr_last;
    logic                   mem_we;
    logic [ADDR_BITS-1:0]   mem_waddr;
    logic [COUNT_BITS-1:0]  mem_wdata;

    assign init_busy   = (state_reg == B_INIT);
    assign sweep       = (state_reg == B_INIT) || (state_reg == B_CLEAR);
    assign ptr_last    = (ptr_reg == ADDR_BITS'(BIN_DEPTH - 1));
    assign cmd_pop     = (state_reg == B_IDLE) && !cmd_empty && !res_full;
    assign frames_next = (frames_reg == '1) ? frames_reg : frames_reg + 1'b1;
    // Saturating increment.
    assign inc         = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + 1'b1;
    assign cnt         = (act_reg == ACT_DEPOSIT) ? inc : rd_data_reg;
    assign cnt_w       = 64'(cnt);
    assign addr_w      = ADDR_W_MAX'(addr_reg);

    assign mem_we    = sweep || ((state_reg == B_UPDATE) && (act_reg == ACT_DEPOSIT));
    assign mem_waddr = sweep ? ptr_reg : addr_reg;
    assign mem_wdata = sweep ? '0 : inc;

    always_comb
    begin
        res_push        = 1'b0;
        res.bin_index   = '0;
        res.bin_count   = '0;
        res.frame_count = frames_reg;
        res.saturated   = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_pop && (cmd.action == ACT_FRAME))
                begin
                    res_push        = 1'b1;
                    res.frame_count = frames_next;
                end
            end
            B_UPDATE:
            begin
                res_push      = 1'b1;
                res.bin_index = addr_w[IDX_W-1:0];
                res.bin_count = cnt_w[OUT_CNT_W-1:0];
                res.saturated = (cnt == '1);
            end
            B_CLEAR:
            begin
                res_push        = ptr_last;
                res.frame_count = '0;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_INIT;
            ptr_reg    <= '0;
            act_reg    <= ACT_DEPOSIT;
            addr_reg   <= '0;
            frames_reg <= '0;
        end
        else
        begin
            case (state_reg)
                B_INIT,
                B_CLEAR:
                begin
                    if (ptr_last)
                    begin
                        ptr_reg   <= '0;
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                B_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        act_reg  <= cmd.action;
                        addr_reg <= cmd.addr[ADDR_BITS-1:0];
                        case (cmd.action)
                            ACT_DEPOSIT,
                            ACT_READ:
                            begin
                                state_reg <= B_UPDATE;
                            end
                            ACT_FRAME:
                            begin
                                frames_reg <= frames_next;
                            end
                            default:
                            begin
                                frames_reg <= '0;
                                ptr_reg    <= '0;
                                state_reg  <= B_CLEAR;
                            end
                        endcase
                    end
                end
                B_UPDATE:
                begin
                    state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Count store: one write port, one registered read port at the queue head.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[cmd.addr[ADDR_BITS-1:0]];
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

endmodule

// File: hdl/periodic_3d_density_binner_unit.sv
`timescale 1ns / 1ps
// Top level of the periodic 3D density binner: configuration registers,
// front end, command queue, back end and result queue. Uses pdb_pkg.
//
// Usage:
//  - Input channel: drive action, pos_x/y/z and read_index with push high;
//    a word is taken at a clock edge where push is high and full is low.
//  - Result channel: while empty is low the oldest result sits on bin_index,
//    bin_count, frame_count and saturated; pop takes it. One result per word.
//  - Configuration: cfg_we writes cfg_data into register cfg_index at the
//    edge; only do so while no word is in flight.
//  - Front end steps per word: a deposit runs wrap, scale, clamp, linear
//    address and push; a read, frame end or clear goes straight to push.
//    Deposits and reads add the modulo, remainder and fix steps when
//    BIN_DEPTH is below the linear index range (none at the defaults).
//    The front end takes a new word only once the last command is queued.
//  - Clear all sweeps the store one entry a cycle.
//  - After reset the same sweep runs with full held high.
//  - A stalled receiver fills the two-entry result queue; the back end then
//    holds, the command queue fills, and full rises.
module periodic_3d_density_binner_unit #(
    parameter int AXIS_BITS  = 5,
    parameter int BIN_DEPTH  = 32768,
    parameter int COUNT_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     action,
    input  logic signed [31:0]             pos_x,
    input  logic signed [31:0]             pos_y,
    input  logic signed [31:0]             pos_z,
    input  logic [14:0]                    read_index,
    output logic                           empty,
    input  logic                           pop,
    output logic [14:0]                    bin_index,
    output logic [31:0]                    bin_count,
    output logic [31:0]                    frame_count,
    output logic                           saturated,
    input  logic                           cfg_we,
    input  logic [pdb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pdb_pkg::CFG_W-1:0]      cfg_data
);

    import pdb_pkg::*;

    localparam int SHAPE_W = 3 * AXIS_BITS;

    // Configuration registers.
    cfg_t               cfg_reg;
    logic [SHAPE_W-1:0] grid_shape_reg;

    logic    front_busy;
    logic    init_busy;
    logic    in_take;
    logic    cmd_push, cmd_pop, cmd_full, cmd_empty;
    cmd_t    cmd_in, cmd_out;
    logic    res_push, res_full;
    result_t res_in, res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_x  <= BOX_W'(655360);
            cfg_reg.box_y  <= BOX_W'(655360);
            cfg_reg.box_z  <= BOX_W'(655360);
            cfg_reg.bpu_x  <= BPU_W'(65536);
            cfg_reg.bpu_y  <= BPU_W'(65536);
            cfg_reg.bpu_z  <= BPU_W'(65536);
            grid_shape_reg <= SHAPE_W'(9513);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BOX_X:      cfg_reg.box_x  <= cfg_data[BOX_W-1:0];
                REG_BOX_Y:      cfg_reg.box_y  <= cfg_data[BOX_W-1:0];
                REG_BOX_Z:      cfg_reg.box_z  <= cfg_data[BOX_W-1:0];
                REG_BPU_X:      cfg_reg.bpu_x  <= cfg_data[BPU_W-1:0];
                REG_BPU_Y:      cfg_reg.bpu_y  <= cfg_data[BPU_W-1:0];
                REG_BPU_Z:      cfg_reg.bpu_z  <= cfg_data[BPU_W-1:0];
                REG_GRID_SHAPE: grid_shape_reg <= cfg_data[SHAPE_W-1:0];
                default:        grid_shape_reg <= grid_shape_reg;
            endcase
        end
    end

    // Hold off new words while the front end works or the reset sweep runs.
    assign full    = front_busy || init_busy;
    assign in_take = push && !full;

    pdb_front #(
        .AXIS_BITS (AXIS_BITS),
        .BIN_DEPTH (BIN_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_take    (in_take),
        .action     (action),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .read_index (read_index),
        .cfg        (cfg_reg),
        .grid_shape (grid_shape_reg),
        .busy       (front_busy),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in),
        .cmd_full   (cmd_full)
    );

    pdb_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .full  (cmd_full),
        .empty (cmd_empty)
    );

    pdb_back #(
        .BIN_DEPTH  (BIN_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in),
        .init_busy (init_busy)
    );

    pdb_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .pop   (pop),
        .rdata (res_out),
        .full  (res_full),
        .empty (empty)
    );

    assign bin_index   = res_out.bin_index;
    assign bin_count   = res_out.bin_count;
    assign frame_count = res_out.frame_count;
    assign saturated   = res_out.saturated;

    a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> full)
        else $error("word accepted during clearing sweep");

    a_take_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> full)
        else $error("front end free right after taking a word");

    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result dropped on full result queue");

    a_cmd_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command dropped on full command queue");

endmodule

// File: bench/periodic_3d_density_binner_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for periodic_3d_density_binner_unit: a mirror of the bin store
// predicts every result word, which is compared field by field as it is popped.
// Depends on pdb_pkg and the RTL of the block only.
module periodic_3d_density_binner_unit_tb;
    import pdb_pkg::*;

    localparam int AXIS_W         = 5;
    localparam int BIN_SLOTS      = 32768;
    localparam int IDLE_PCT       = 19;
    localparam int SETTLE_CYCLES  = 16;
    // A clear sweep can hold the input side with nothing moving;
    // allow several sweeps' worth of silence before calling it a hang.
    localparam int WATCHDOG_LIMIT = 4 * BIN_SLOTS + 20000;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  push       = 1'b0;
    logic                  full;
    logic [1:0]            action     = ACT_DEPOSIT;
    logic signed [31:0]    pos_x      = '0;
    logic signed [31:0]    pos_y      = '0;
    logic signed [31:0]    pos_z      = '0;
    logic [14:0]           read_index = '0;
    logic                  empty;
    logic                  pop        = 1'b0;
    logic [14:0]           bin_index;
    logic [31:0]           bin_count;
    logic [31:0]           frame_count;
    logic                  saturated;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_BOX_X;
    logic [CFG_W-1:0]      cfg_data   = '0;

    // Mirror of the block's geometry registers, at their reset values.
    logic [30:0]           geom_box [3] = '{31'd655360, 31'd655360, 31'd655360};
    logic [31:0]           geom_bpu [3] = '{32'd65536, 32'd65536, 32'd65536};
    logic [14:0]           geom_shape   = 15'd9513;

    // Mirror of the count store and the frame counter.
    logic [31:0]           tally_mirror [BIN_SLOTS];
    logic [31:0]           frames_mirror = '0;
    int unsigned           last_touched  = 0;

    // Result words still owed by the block, oldest first.
    result_t               awaited_tallies [$];

    bit                    steady = 1'b0;
    int                    mismatches      = 0;
    int                    tallies_checked = 0;
    int                    settings_used   = 0;
    int                    sent_by_action [4] = '{0, 0, 0, 0};
    int                    idle_cycles     = 0;

    periodic_3d_density_binner_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .read_index  (read_index),
        .empty       (empty),
        .pop         (pop),
        .bin_index   (bin_index),
        .bin_count   (bin_count),
        .frame_count (frame_count),
        .saturated   (saturated),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        foreach (tally_mirror[i]) tally_mirror[i] = '0;
    end

    // Wrap one coordinate into the box once, scale it by bins per unit and
    // clamp to the last bin. Still negative after the wrap means bin 0.
    function automatic int unsigned axis_slot(logic [31:0] coord, logic [30:0] box,
                                              logic [31:0] bpu, int unsigned nbins);
        longint      p;
        longint      span;
        logic [63:0] prod;
        p    = longint'(signed'(coord));
        span = longint'(box);
        if (p >= span) p = p - span;
        else if (p < 0) p = p + span;
        if (p < 0) return 0;
        prod = 64'(p) * 64'(bpu);
        if (prod[63:32] > nbins - 1) return nbins - 1;
        return prod[63:32];
    endfunction

    // Apply one word to the mirror and return the result word it must produce.
    function automatic result_t tally_word(action_t act, logic [31:0] px, logic [31:0] py,
                                           logic [31:0] pz, logic [14:0] ridx);
        result_t     r;
        int unsigned nx, ny, nz, ix, iy, iz, lin;
        r = '0;
        case (act)
            ACT_DEPOSIT:
            begin
                nx  = int'(geom_shape[AXIS_W-1:0]) + 1;
                ny  = int'(geom_shape[2*AXIS_W-1:AXIS_W]) + 1;
                nz  = int'(geom_shape[3*AXIS_W-1:2*AXIS_W]) + 1;
                ix  = axis_slot(px, geom_box[0], geom_bpu[0], nx);
                iy  = axis_slot(py, geom_box[1], geom_bpu[1], ny);
                iz  = axis_slot(pz, geom_box[2], geom_bpu[2], nz);
                lin = ((ix * ny + iy) * nz + iz) % BIN_SLOTS;
                if (tally_mirror[lin] != '1) tally_mirror[lin]++;
                last_touched  = lin;
                r.bin_index   = 15'(lin);
                r.bin_count   = tally_mirror[lin];
                r.saturated   = (tally_mirror[lin] == '1);
            end
            ACT_FRAME:
            begin
                if (frames_mirror != '1) frames_mirror++;
            end
            ACT_READ:
            begin
                lin         = ridx % BIN_SLOTS;
                r.bin_index = 15'(lin);
                r.bin_count = tally_mirror[lin];
                r.saturated = (tally_mirror[lin] == '1);
            end
            default:
            begin
                foreach (tally_mirror[i]) tally_mirror[i] = '0;
                frames_mirror = '0;
            end
        endcase
        r.frame_count = frames_mirror;
        return r;
    endfunction

    // Pick a coordinate for an axis: mostly inside the box, some within one wrap
    // on either side, the rest anywhere in the 32-bit range.
    function automatic logic [31:0] pick_coord(logic [30:0] box);
        logic [31:0] b;
        int unsigned roll;
        b    = {1'b0, box};
        roll = $urandom_range(99, 0);
        if (b == 0 || roll >= 85) return $urandom();
        if (roll < 55) return $urandom_range(b - 1, 0);
        if (roll < 70) return -$urandom_range(b, 1);
        return b + $urandom_range(b - 1, 0);
    endfunction

    // Offer one word and hold it until the block takes it, then book the result
    // it owes. Fields the action ignores carry noise.
    task automatic send_word(input action_t act, input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [14:0] ridx);
        logic [31:0] xv, yv, zv;
        logic [14:0] rv;
        xv = (act == ACT_DEPOSIT) ? px : $urandom();
        yv = (act == ACT_DEPOSIT) ? py : $urandom();
        zv = (act == ACT_DEPOSIT) ? pz : $urandom();
        rv = (act == ACT_READ) ? ridx : 15'($urandom());
        while (!steady && $urandom_range(99, 0) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        action     <= act;
        pos_x      <= xv;
        pos_y      <= yv;
        pos_z      <= zv;
        read_index <= rv;
        @(posedge clk);
        while (full) @(posedge clk);
        awaited_tallies.push_back(tally_word(act, xv, yv, zv, rv));
        sent_by_action[act]++;
    endtask

    // Drop push, drain every owed result, let a clear sweep finish, then pause.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (awaited_tallies.size() != 0 || full) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all seven geometry registers back to back while the block is idle.
    task automatic program_regs(input logic [31:0] bx, input logic [31:0] by,
                                input logic [31:0] bz, input logic [31:0] ux,
                                input logic [31:0] uy, input logic [31:0] uz,
                                input logic [14:0] shape);
        cfg_reg_t    ids  [7];
        logic [31:0] vals [7];
        ids  = '{REG_BOX_X, REG_BOX_Y, REG_BOX_Z, REG_BPU_X, REG_BPU_Y, REG_BPU_Z,
                 REG_GRID_SHAPE};
        vals = '{bx, by, bz, ux, uy, uz, {17'd0, shape}};
        wait_idle();
        for (int i = 0; i < 7; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= ids[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        geom_box[0] = bx[30:0];
        geom_box[1] = by[30:0];
        geom_box[2] = bz[30:0];
        geom_bpu[0] = ux;
        geom_bpu[1] = uy;
        geom_bpu[2] = uz;
        geom_shape  = shape;
        settings_used++;
    endtask

    // Reset geometry (10 bins of 1.0 per axis): box edges, one wrap from each
    // side, values still outside after one wrap, a repeated bin, frames, reads
    // of touched and untouched bins, and a clear followed by a read.
    task automatic test_default_geometry();
        send_word(ACT_DEPOSIT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, '0);
        send_word(ACT_DEPOSIT, 32'h0009_FFFF, 32'h0009_FFFF, 32'h0009_FFFF, '0);
        send_word(ACT_DEPOSIT, 32'h000A_0000, 32'hFFFF_FFFF, 32'hFFF6_0000, '0);
        send_word(ACT_DEPOSIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, '0);
        send_word(ACT_DEPOSIT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, '0);
        send_word(ACT_FRAME, '0, '0, '0, '0);
        send_word(ACT_READ, '0, '0, '0, 15'd0);
        send_word(ACT_READ, '0, '0, '0, 15'h7FFF);
        send_word(ACT_CLEAR, '0, '0, '0, '0);
        send_word(ACT_READ, '0, '0, '0, 15'd0);
        send_word(ACT_FRAME, '0, '0, '0, '0);
        send_word(ACT_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    endtask

    // Largest box, largest scale and 32 bins per axis: products far past the
    // last bin clamp to it, and the linear index reaches the top of the store.
    task automatic test_extreme_geometry();
        program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h7FFF);
        send_word(ACT_DEPOSIT, 32'h7FFF_FFFE, 32'h7FFF_FFFE, 32'h7FFF_FFFE, '0);
        send_word(ACT_DEPOSIT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0);
        send_word(ACT_DEPOSIT, 32'h0000_0001, 32'h0000_0002, 32'h4000_0000, '0);
        send_word(ACT_READ, '0, '0, '0, 15'h7FFF);
        send_word(ACT_READ, '0, '0, '0, 15'd0);
    endtask

    // Zero box length and zero scale on a full grid, then one bin per axis
    // with the largest scale: every deposit must land in bin 0.
    task automatic test_degenerate_geometry();
        program_regs(32'd0, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 15'h7FFF);
        send_word(ACT_DEPOSIT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0);
        send_word(ACT_DEPOSIT, 32'h0000_1000, 32'h0000_0000, 32'hFFFF_FFFB, '0);
        send_word(ACT_READ, '0, '0, '0, 15'd0);
        program_regs(32'd1, 32'd1, 32'd1,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'd0);
        send_word(ACT_DEPOSIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, '0);
        send_word(ACT_READ, '0, '0, '0, 15'h7FFF);
        send_word(ACT_FRAME, '0, '0, '0, '0);
    endtask

    // Back-to-back deposits into a handful of hot bins on a 4x4x4 grid with no
    // idling on either side: this is where read-modify-write of a bin must hold up.
    task automatic test_hot_bin_burst();
        logic [31:0] hot [3][3];
        int unsigned pick, roll;
        hot = '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
                '{32'h0001_8000, 32'h0002_0000, 32'h0003_FFFF},
                '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}};
        program_regs(32'h0004_0000, 32'h0004_0000, 32'h0004_0000,
                     32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 15'd3171);
        steady = 1'b1;
        for (int w = 0; w < 50; w++)
        begin
            roll = $urandom_range(99, 0);
            pick = $urandom_range(2, 0);
            if (roll < 65)
                send_word(ACT_DEPOSIT, hot[pick][0], hot[pick][1], hot[pick][2], '0);
            else if (roll < 80)
                send_word(ACT_DEPOSIT, pick_coord(geom_box[0]), pick_coord(geom_box[1]),
                          pick_coord(geom_box[2]), '0);
            else if (roll < 92)
                send_word(ACT_READ, '0, '0, '0, 15'(last_touched));
            else
                send_word(ACT_FRAME, '0, '0, '0, '0);
        end
        steady = 1'b0;
    endtask

    // Random geometries, each followed by a stream of mostly deposits with
    // random reads, frame ends and the odd clear. One phase runs without idling.
    task automatic test_random_geometry();
        logic [31:0] box [3];
        logic [31:0] bpu [3];
        logic [31:0] pos [3];
        logic [14:0] shape;
        longint      q;
        int unsigned n, roll;
        bit          have_pos;
        for (int phase = 0; phase < 5; phase++)
        begin
            shape = 15'($urandom_range(32767, 0));
            for (int a = 0; a < 3; a++)
            begin
                n = shape[a*AXIS_W +: AXIS_W] + 1;
                if ($urandom_range(4, 0) == 0) box[a] = $urandom_range(32'h7FFF_FFFF, 1);
                else box[a] = $urandom_range(100 << 16, 1 << 16);
                if ($urandom_range(4, 0) == 0)
                    bpu[a] = $urandom();
                else
                begin
                    // Aim the scale at the bin count, with some overshoot to clamp.
                    q = (longint'(n) << 32) / box[a] * $urandom_range(120, 90) / 100;
                    bpu[a] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(q);
                end
            end
            program_regs(box[0], box[1], box[2], bpu[0], bpu[1], bpu[2], shape);
            steady   = (phase == 2);
            have_pos = 1'b0;
            for (int w = 0; w < 96; w++)
            begin
                roll = $urandom_range(99, 0);
                if (roll < 70)
                begin
                    // Revisit the last atom now and then so bins get hit repeatedly.
                    if (!have_pos || $urandom_range(3, 0) != 0)
                        for (int a = 0; a < 3; a++) pos[a] = pick_coord(geom_box[a]);
                    have_pos = 1'b1;
                    send_word(ACT_DEPOSIT, pos[0], pos[1], pos[2], '0);
                end
                else if (roll < 84)
                    send_word(ACT_READ, '0, '0, '0,
                              $urandom_range(1, 0) ? 15'(last_touched)
                                                   : 15'($urandom_range(32767, 0)));
                else if (roll < 99)
                    send_word(ACT_FRAME, '0, '0, '0, '0);
                else
                    send_word(ACT_CLEAR, '0, '0, '0, '0);
            end
            steady = 1'b0;
        end
    endtask

    // Result side: pop at random (always during steady stretches) and compare
    // each accepted word with the oldest owed result.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (awaited_tallies.size() == 0)
                begin
                    $error("unexpected result word: bin_index %0d bin_count %0d",
                           bin_index, bin_count);
                    mismatches++;
                end
                else
                begin
                    want = awaited_tallies.pop_front();
                    tallies_checked++;
                    if (bin_index !== want.bin_index)
                    begin
                        $error("bin_index: expected %0d, actual %0d",
                               want.bin_index, bin_index);
                        mismatches++;
                    end
                    if (bin_count !== want.bin_count)
                    begin
                        $error("bin_count: expected %0d, actual %0d",
                               want.bin_count, bin_count);
                        mismatches++;
                    end
                    if (frame_count !== want.frame_count)
                    begin
                        $error("frame_count: expected %0d, actual %0d",
                               want.frame_count, frame_count);
                        mismatches++;
                    end
                    if (saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0d, actual %0d",
                               want.saturated, saturated);
                        mismatches++;
                    end
                end
            end
            pop <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    // Hang detector: count cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("periodic_3d_density_binner_unit verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_default_geometry();
        test_extreme_geometry();
        test_degenerate_geometry();
        test_hot_bin_burst();
        test_random_geometry();
        wait_idle();
        $display("Covered %0d deposits, %0d reads, %0d frame ends and %0d clears",
                 sent_by_action[ACT_DEPOSIT], sent_by_action[ACT_READ],
                 sent_by_action[ACT_FRAME], sent_by_action[ACT_CLEAR]);
        $display("over %0d register settings; %0d result words compared, %0d mismatches",
                 settings_used + 1, tallies_checked, mismatches);
        if (mismatches == 0 && awaited_tallies.size() == 0)
            $display("periodic_3d_density_binner_unit verification clean");
        else
            $display("periodic_3d_density_binner_unit verification failed");
        $finish;
    end

endmodule
